// ===== hdl/pse_pkg.sv =====
package pse_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int FRAC_BITS   = 16;
	localparam int DATA_W      = 64;
	localparam int PTR_W       = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

	localparam int CMD_W  = 2;
	localparam int OPND_W = 24;
	localparam int OP_W   = 2;
	localparam int HUND_W = 48;
	localparam int STAT_W = 3;

	// report arithmetic widths
	localparam int Q_W  = DATA_W - FRAC_BITS;
	localparam int H_W  = Q_W + 8;
	localparam int FR_W = FRAC_BITS + 7;

	// divider: two quotient bits per cycle over a 2*DATA_W bit numerator
	localparam int DIV_PER_CYC = 2;
	localparam int DIV_CYC     = (2 * DATA_W) / DIV_PER_CYC;
	localparam int DIV_CNT_W   = $clog2(DIV_CYC);

	localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_APPLY  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FINISH = 2'd2;

	localparam logic [OP_W-1:0] OP_ADD = 2'd0;
	localparam logic [OP_W-1:0] OP_SUB = 2'd1;
	localparam logic [OP_W-1:0] OP_MUL = 2'd2;
	localparam logic [OP_W-1:0] OP_DIV = 2'd3;

	localparam logic [STAT_W-1:0] ST_OK    = 3'd0;
	localparam logic [STAT_W-1:0] ST_UNDER = 3'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 3'd2;
	localparam logic [STAT_W-1:0] ST_DIV0  = 3'd3;
	localparam logic [STAT_W-1:0] ST_SAT   = 3'd4;

	typedef struct packed {
		logic              ovf;
		logic [DATA_W-1:0] quo;
	} div_res_t;

	typedef struct packed {
		logic              sat;
		logic [DATA_W-1:0] val;
	} sat_val_t;

	// Apply a sign to a magnitude; saturate when it does not fit.
	function automatic sat_val_t sign_from_mag(input logic neg, input logic [DATA_W-1:0] mag,
			input logic ovf);
		sat_val_t r;
		if (neg) begin
			if (ovf || (mag[DATA_W-1] && (|mag[DATA_W-2:0]))) begin
				r.sat = 1'b1;
				r.val = {1'b1, {(DATA_W-1){1'b0}}};
			end else begin
				r.sat = 1'b0;
				r.val = -mag;
			end
		end else begin
			if (ovf || mag[DATA_W-1]) begin
				r.sat = 1'b1;
				r.val = {1'b0, {(DATA_W-1){1'b1}}};
			end else begin
				r.sat = 1'b0;
				r.val = mag;
			end
		end
		return r;
	endfunction

endpackage

// ===== hdl/pse_ram.sv =====
module pse_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/pse_div.sv =====
module pse_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [pse_pkg::DATA_W-1:0] dividend,
	input  logic [pse_pkg::DATA_W-1:0] divisor,
	output logic                      done,
	output pse_pkg::div_res_t         res
);

	import pse_pkg::*;

	logic [2*DATA_W-1:0] n_q, n_nx;
	logic [DATA_W-1:0]   r_q, r_nx, d_q, q_q, q_nx;
	logic                ovf_q, ovf_nx;
	logic [DATA_W:0]     rx;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                run_q, done_q;

	// restoring division, DIV_PER_CYC bits per cycle
	always_comb begin
		r_nx   = r_q;
		n_nx   = n_q;
		q_nx   = q_q;
		ovf_nx = ovf_q;
		rx     = '0;
		for (int i = 0; i < DIV_PER_CYC; i++) begin
			rx     = {r_nx, n_nx[2*DATA_W-1]};
			n_nx   = {n_nx[2*DATA_W-2:0], 1'b0};
			ovf_nx = ovf_nx | q_nx[DATA_W-1];
			q_nx   = {q_nx[DATA_W-2:0], 1'b0};
			if (rx >= {1'b0, d_q}) begin
				rx      = rx - {1'b0, d_q};
				q_nx[0] = 1'b1;
			end
			r_nx = rx[DATA_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= {{(DATA_W-FRAC_BITS){1'b0}}, dividend, {FRAC_BITS{1'b0}}};
			r_q   <= '0;
			q_q   <= '0;
			ovf_q <= 1'b0;
			d_q   <= divisor;
		end else if (run_q) begin
			n_q   <= n_nx;
			r_q   <= r_nx;
			q_q   <= q_nx;
			ovf_q <= ovf_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= !start && run_q && (cnt_q == DIV_CNT_W'(DIV_CYC - 1));
			if (start) begin
				cnt_q <= '0;
				run_q <= 1'b1;
			end else if (run_q) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(DIV_CYC - 1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	assign done    = done_q;
	assign res.quo = q_q;
	assign res.ovf = ovf_q;

endmodule

// ===== hdl/postfix_stack_evaluator.sv =====
// Postfix expression evaluator on a 64-entry stack of signed Q47.16 values held
// in a single-port-write, registered-read RAM. One result beat comes out for every
// input beat: the stack top times 100 rounded half up (clamped to 48 bits), the
// depth after the token, a status code and an end-of-expression flag. Push, finish,
// the unused command and an operator that underflows go through the top read,
// report and emit; a divide by zero first reads both operands and executes; add and
// subtract read the two operands from the RAM, execute and write back ahead of the
// top read and report; multiply runs four 32x32 partial products through one
// multiplier, accumulates, then saturates; divide waits on the iterative divider,
// which retires two quotient bits per cycle over a 128-bit numerator. in_stall is
// high while a token is in flight; a finished beat waits in the output register,
// and the next token is taken meanwhile. A result that cannot leave because the
// previous beat is still held waits in the emit state while out_stall is high.
module postfix_stack_evaluator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [pse_pkg::CMD_W-1:0]         cmd,
	input  logic [pse_pkg::OPND_W-1:0]        operand,
	input  logic [pse_pkg::OP_W-1:0]          operator,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [pse_pkg::HUND_W-1:0] top_hundredths,
	output logic [pse_pkg::CNT_W-1:0]         depth,
	output logic [pse_pkg::STAT_W-1:0]        status,
	output logic                              done_res
);

	import pse_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_RD_B, S_RD_A, S_EXEC, S_MUL, S_MUL_END, S_DIV, S_WB,
		S_RD_TOP, S_REPORT, S_EMIT
	} state_t;

	localparam logic signed [H_W-1:0] H_MAX = {{(H_W-HUND_W+1){1'b0}}, {(HUND_W-1){1'b1}}};
	localparam logic signed [H_W-1:0] H_MIN = {{(H_W-HUND_W+1){1'b1}}, {(HUND_W-1){1'b0}}};
	localparam int HALF = DATA_W / 2;

	state_t              state_q;
	logic [CNT_W-1:0]    count_q;
	logic [CMD_W-1:0]    cmd_q;
	logic [OP_W-1:0]     op_q;
	logic [STAT_W-1:0]   stat_q;
	logic                neg_q;
	logic [DATA_W-1:0]   a_q, b_q, res_q;
	logic                sat_q;
	logic [HUND_W-1:0]   hund_q;
	logic [2:0]          mstep_q;
	logic [1:0]          pidx_q;
	logic [DATA_W-1:0]   p_s1;
	logic [2*DATA_W-1:0] acc_q;

	logic                accept, full, emit_go;
	logic                ram_we;
	logic [PTR_W-1:0]    ram_waddr, ram_raddr;
	logic [DATA_W-1:0]   ram_wdata, ram_rdata;
	logic [CNT_W-1:0]    cnt_m1, cnt_m2;

	logic [DATA_W-1:0]   sum, diff, mag_a, mag_b;
	logic                add_ovf, sub_ovf;
	logic [DATA_W-1:0]   lim;
	logic [HALF-1:0]     mul_x, mul_y;
	logic [DATA_W-1:0]   mul_p;
	logic [2*DATA_W-1:0] p_shift;
	sat_val_t            mul_sv, div_sv;

	logic                div_start, div_done;
	div_res_t            div_res;

	logic signed [H_W-1:0] hq, h;
	logic [FR_W-1:0]       frac_r;
	logic [HUND_W-1:0]     hund;
	logic                  rsat;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign full     = (count_q == CNT_W'(STACK_DEPTH));
	assign cnt_m1   = count_q - CNT_W'(1);
	assign cnt_m2   = count_q - CNT_W'(2);
	// load the output register when it is empty or being taken
	assign emit_go  = (state_q == S_EMIT) && (!out_valid || !out_stall);

	// Read port: the top on accept and before the report, the second entry after it.
	assign ram_raddr = (state_q == S_RD_B) ? cnt_m2[PTR_W-1:0] : cnt_m1[PTR_W-1:0];

	// Write port: push lands at count, an operator result replaces the second entry.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = count_q[PTR_W-1:0];
		ram_wdata = {{(DATA_W-OPND_W-FRAC_BITS){1'b0}}, operand, {FRAC_BITS{1'b0}}};
		if (accept && cmd == CMD_PUSH && !full) begin
			ram_we = 1'b1;
		end else if (state_q == S_WB) begin
			ram_we    = 1'b1;
			ram_waddr = cnt_m2[PTR_W-1:0];
			ram_wdata = res_q;
		end
	end

	pse_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Add and subtract saturate toward the sign of the left operand.
	assign sum     = a_q + b_q;
	assign diff    = a_q - b_q;
	assign add_ovf = (a_q[DATA_W-1] == b_q[DATA_W-1]) && (sum[DATA_W-1] != a_q[DATA_W-1]);
	assign sub_ovf = (a_q[DATA_W-1] != b_q[DATA_W-1]) && (diff[DATA_W-1] != a_q[DATA_W-1]);
	assign lim     = a_q[DATA_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
	assign mag_a   = a_q[DATA_W-1] ? -a_q : a_q;
	assign mag_b   = b_q[DATA_W-1] ? -b_q : b_q;

	// Multiply magnitudes as four half-width partial products, one per cycle.
	assign mul_x = mstep_q[1] ? mag_a[DATA_W-1:HALF] : mag_a[HALF-1:0];
	assign mul_y = mstep_q[0] ? mag_b[DATA_W-1:HALF] : mag_b[HALF-1:0];
	assign mul_p = mul_x * mul_y;

	always_comb begin
		case (pidx_q)
			2'd0:    p_shift = {{DATA_W{1'b0}}, p_s1};
			2'd3:    p_shift = {p_s1, {DATA_W{1'b0}}};
			default: p_shift = {{HALF{1'b0}}, p_s1, {HALF{1'b0}}};
		endcase
	end

	assign mul_sv = sign_from_mag(neg_q, acc_q[DATA_W-1+FRAC_BITS:FRAC_BITS],
		|acc_q[2*DATA_W-1:DATA_W+FRAC_BITS]);

	assign div_start = (state_q == S_EXEC) && (op_q == OP_DIV) && (b_q != '0);

	pse_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mag_a),
		.divisor  (mag_b),
		.done     (div_done),
		.res      (div_res)
	);

	assign div_sv = sign_from_mag(neg_q, div_res.quo, div_res.ovf);

	// Report: floor(top * 100 + 1/2) as integer part times 100 plus rounded fraction.
	assign hq     = $signed({{(H_W-Q_W){ram_rdata[DATA_W-1]}}, ram_rdata[DATA_W-1:FRAC_BITS]})
		* $signed(H_W'(100));
	assign frac_r = {7'd0, ram_rdata[FRAC_BITS-1:0]} * FR_W'(100) + FR_W'(1 << (FRAC_BITS - 1));
	assign h      = hq + $signed({{(H_W-7){1'b0}}, frac_r[FR_W-1:FRAC_BITS]});

	always_comb begin
		rsat = 1'b0;
		hund = h[HUND_W-1:0];
		if (count_q == '0) begin
			hund = '0;
		end else if (h > H_MAX) begin
			rsat = 1'b1;
			hund = H_MAX[HUND_W-1:0];
		end else if (h < H_MIN) begin
			rsat = 1'b1;
			hund = H_MIN[HUND_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			count_q        <= '0;
			cmd_q          <= '0;
			op_q           <= '0;
			stat_q         <= ST_OK;
			neg_q          <= 1'b0;
			a_q            <= '0;
			b_q            <= '0;
			res_q          <= '0;
			sat_q          <= 1'b0;
			hund_q         <= '0;
			mstep_q        <= '0;
			pidx_q         <= '0;
			p_s1           <= '0;
			acc_q          <= '0;
			out_valid      <= 1'b0;
			top_hundredths <= '0;
			depth          <= '0;
			status         <= ST_OK;
			done_res       <= 1'b0;
		end else begin
			// drop the output beat once taken, unless a new one replaces it
			if (out_valid && !out_stall && !emit_go) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q <= cmd;
						op_q  <= operator;
						sat_q <= 1'b0;
						if (cmd == CMD_PUSH && full) begin
							stat_q <= ST_FULL;
						end else if (cmd == CMD_APPLY && count_q < CNT_W'(2)) begin
							stat_q <= ST_UNDER;
						end else if (cmd == CMD_FINISH && count_q == '0) begin
							stat_q <= ST_UNDER;
						end else begin
							stat_q <= ST_OK;
						end
						if (cmd == CMD_PUSH && !full) begin
							count_q <= count_q + CNT_W'(1);
						end
						if (cmd == CMD_APPLY && count_q >= CNT_W'(2)) begin
							state_q <= S_RD_B;
						end else begin
							state_q <= S_RD_TOP;
						end
					end
				end
				S_RD_B: begin
					b_q     <= ram_rdata;
					state_q <= S_RD_A;
				end
				S_RD_A: begin
					a_q     <= ram_rdata;
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					neg_q <= a_q[DATA_W-1] ^ b_q[DATA_W-1];
					case (op_q)
						OP_ADD: begin
							res_q   <= add_ovf ? lim : sum;
							sat_q   <= add_ovf;
							state_q <= S_WB;
						end
						OP_SUB: begin
							res_q   <= sub_ovf ? lim : diff;
							sat_q   <= sub_ovf;
							state_q <= S_WB;
						end
						OP_MUL: begin
							acc_q   <= '0;
							mstep_q <= '0;
							state_q <= S_MUL;
						end
						default: begin
							// divide by zero leaves the stack as it was
							if (b_q == '0) begin
								stat_q  <= ST_DIV0;
								state_q <= S_RD_TOP;
							end else begin
								state_q <= S_DIV;
							end
						end
					endcase
				end
				S_MUL: begin
					// register each partial product, accumulate it in the following cycle
					if (mstep_q < 3'd4) begin
						p_s1   <= mul_p;
						pidx_q <= mstep_q[1:0];
					end
					if (mstep_q != 3'd0) begin
						acc_q <= acc_q + p_shift;
					end
					mstep_q <= mstep_q + 3'd1;
					if (mstep_q == 3'd4) begin
						state_q <= S_MUL_END;
					end
				end
				S_MUL_END: begin
					res_q   <= mul_sv.val;
					sat_q   <= mul_sv.sat;
					state_q <= S_WB;
				end
				S_DIV: begin
					if (div_done) begin
						res_q   <= div_sv.val;
						sat_q   <= div_sv.sat;
						state_q <= S_WB;
					end
				end
				S_WB: begin
					count_q <= cnt_m1;
					if (sat_q) begin
						stat_q <= ST_SAT;
					end
					state_q <= S_RD_TOP;
				end
				S_RD_TOP: begin
					// read of the top is in flight
					state_q <= S_REPORT;
				end
				S_REPORT: begin
					hund_q <= hund;
					if (rsat && stat_q == ST_OK) begin
						stat_q <= ST_SAT;
					end
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					// hold until the output register is free
					if (emit_go) begin
						out_valid      <= 1'b1;
						top_hundredths <= hund_q;
						status         <= stat_q;
						done_res       <= (cmd_q == CMD_FINISH);
						if (cmd_q == CMD_FINISH) begin
							depth   <= '0;
							count_q <= '0;
						end else begin
							depth <= count_q;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
